[rtl/kst_pkg.sv]
// Shared types, codes and default keymaps for the set-1 scancode translator.
// Used by every module of the block except kst_ram; depends on nothing.

package kst_pkg;

    localparam int FIRST_HIGH_CODE = 89;
    localparam int ESC_DEPTH       = 128;

    localparam logic [7:0] SC_E0    = 8'hE0;
    localparam logic [7:0] SC_E1    = 8'hE1;
    localparam logic [7:0] SC_1D    = 8'h1D;
    localparam logic [7:0] SC_45    = 8'h45;
    localparam logic [7:0] SC_LSHFT = 8'h2A;
    localparam logic [7:0] SC_RSHFT = 8'h36;

    localparam logic [6:0] PAUSE_KEY = 7'd119;

    typedef enum logic [1:0] {
        REQ_XLATE = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_BAD   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_CONSUMED = 2'd1,
        ST_UNKNOWN  = 2'd2,
        ST_INVALID  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PS_NONE  = 2'd0,
        PS_E0    = 2'd1,
        PS_E1    = 2'd2,
        PS_E1_1D = 2'd3
    } prefix_t;

    // table access issued at the input handshake
    typedef struct packed {
        logic       rd_en;
        logic       hi_we;
        logic       esc_we;
        logic [6:0] code;
        logic [6:0] wdata;
    } tbl_req_t;

    // item held in the input register
    typedef struct packed {
        req_t       req;
        logic [7:0] scancode;
        logic       nk_bad;
    } item_t;

    typedef struct packed {
        status_t    status;
        logic [6:0] keycode;
    } res_t;

    // unprefixed keymap, indexed by scancode
    function automatic logic [6:0] high_default(input logic [6:0] code);
        logic [6:0] kc;
        kc = 7'd0;
        unique case (code)
            7'h59:   kc = 7'd124;
            7'h5A:   kc = 7'd125;
            7'h5B:   kc = 7'd126;
            7'h5C:   kc = 7'd127;
            7'h6D:   kc = 7'd122;
            7'h6F:   kc = 7'd123;
            7'h73:   kc = 7'd89;
            7'h74:   kc = 7'd120;
            7'h77:   kc = 7'd90;
            7'h78:   kc = 7'd91;
            7'h79:   kc = 7'd92;
            7'h7A:   kc = 7'd93;
            7'h7B:   kc = 7'd94;
            7'h7C:   kc = 7'd95;
            7'h7D:   kc = 7'd124;
            7'h7E:   kc = 7'd121;
            default: kc = 7'd0;
        endcase
        return kc;
    endfunction

    // E0 keymap
    function automatic logic [6:0] esc_default(input logic [6:0] code);
        logic [6:0] kc;
        kc = 7'd0;
        unique case (code)
            7'h1C:   kc = 7'd96;
            7'h1D:   kc = 7'd97;
            7'h35:   kc = 7'd98;
            7'h37:   kc = 7'd99;
            7'h38:   kc = 7'd100;
            7'h3D:   kc = 7'd113;
            7'h3E:   kc = 7'd114;
            7'h3F:   kc = 7'd115;
            7'h40:   kc = 7'd116;
            7'h41:   kc = 7'd117;
            7'h46:   kc = 7'd101;
            7'h47:   kc = 7'd102;
            7'h48:   kc = 7'd103;
            7'h49:   kc = 7'd104;
            7'h4B:   kc = 7'd105;
            7'h4C:   kc = 7'd124;
            7'h4D:   kc = 7'd106;
            7'h4E:   kc = 7'd118;
            7'h4F:   kc = 7'd107;
            7'h50:   kc = 7'd108;
            7'h51:   kc = 7'd109;
            7'h52:   kc = 7'd110;
            7'h53:   kc = 7'd111;
            7'h5B:   kc = 7'd125;
            7'h5C:   kc = 7'd126;
            7'h5D:   kc = 7'd127;
            7'h6F:   kc = 7'd112;
            default: kc = 7'd0;
        endcase
        return kc;
    endfunction

endpackage

[rtl/keyboard_scancode_to_keycode_core.sv]
// Top level of the set-1 scancode translator: handshakes, input and result
// registers. Depends on kst_pkg, kst_tables, kst_xlate.

// Takes one item per clock when the output is not stalled and returns exactly
// one result item for each, in order. Acceptance reads both keymap RAMs into
// the input register stage; the E0/E1 prefix logic then runs into the result
// register. Table writes land at the input handshake, so a read or translate
// right behind a write sees the new entry. Both keymaps come out of reset with
// their default contents at once (per-entry written flags, no clearing pass).
module keyboard_scancode_to_keycode_core #(
    parameter int FIRST_HIGH_CODE = kst_pkg::FIRST_HIGH_CODE
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // scancode[7:0], new_keycode[15:8]
    input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // keycode_out[6:0], zero pad[7]
    output logic [1:0]  m_axis_tuser   // status[1:0]
);

    localparam logic [6:0] FHC7 = 7'(FIRST_HIGH_CODE);

    logic              accept;
    logic              advance;
    logic              s1_valid_reg;
    kst_pkg::item_t    s1_item_reg;
    logic              m_valid_reg;
    kst_pkg::res_t     m_res_reg;
    kst_pkg::res_t     result;
    kst_pkg::tbl_req_t tbl_req;
    kst_pkg::req_t     req_in;
    logic [7:0]        sc_in;
    logic [7:0]        nk_in;
    logic              addr_ok;
    logic              wr_ok;
    logic [6:0]        hi_entry;
    logic [6:0]        esc_entry;

    assign req_in  = kst_pkg::req_t'(s_axis_tuser);
    assign sc_in   = s_axis_tdata[7:0];
    assign nk_in   = s_axis_tdata[15:8];

    assign advance       = s1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign addr_ok = sc_in[7] || (sc_in[6:0] >= FHC7);
    assign wr_ok   = accept && (req_in == kst_pkg::REQ_WRITE) && addr_ok && !nk_in[7];

    always_comb
    begin
        tbl_req.rd_en  = accept;
        tbl_req.hi_we  = wr_ok && !sc_in[7];
        tbl_req.esc_we = wr_ok && sc_in[7];
        tbl_req.code   = sc_in[6:0];
        tbl_req.wdata  = nk_in[6:0];
    end

    kst_tables #(
        .FIRST_HIGH_CODE (FIRST_HIGH_CODE)
    ) u_tables (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (tbl_req),
        .held_code (s1_item_reg.scancode[6:0]),
        .hi_entry  (hi_entry),
        .esc_entry (esc_entry)
    );

    kst_xlate #(
        .FIRST_HIGH_CODE (FIRST_HIGH_CODE)
    ) u_xlate (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (s1_item_reg),
        .hi_entry  (hi_entry),
        .esc_entry (esc_entry),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (!m_valid_reg || m_axis_tready)
            begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.req      <= req_in;
            s1_item_reg.scancode <= sc_in;
            s1_item_reg.nk_bad   <= nk_in[7];
        end
        if (advance)
        begin
            m_res_reg <= result;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_res_reg.keycode};
    assign m_axis_tuser  = m_res_reg.status;

endmodule

[rtl/kst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module kst_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/kst_tables.sv]
// High-code and E0 keymap tables: two RAMs plus per-entry written flags, so an
// entry never written reads as its default. Depends on kst_pkg and kst_ram.

module kst_tables #(
    parameter int FIRST_HIGH_CODE = kst_pkg::FIRST_HIGH_CODE
) (
    input  logic              clk,
    input  logic              rst_n,
    input  kst_pkg::tbl_req_t req,
    input  logic [6:0]        held_code,
    output logic [6:0]        hi_entry,
    output logic [6:0]        esc_entry
);

    localparam int HIGH_DEPTH = 128 - FIRST_HIGH_CODE;
    localparam int HAW        = (HIGH_DEPTH > 1) ? $clog2(HIGH_DEPTH) : 1;
    localparam logic [6:0] FHC7 = 7'(FIRST_HIGH_CODE);

    logic [HAW-1:0]        hi_addr;
    logic [6:0]            hi_rdata;
    logic [6:0]            esc_rdata;
    logic [HIGH_DEPTH-1:0] hi_vld_reg;
    logic [kst_pkg::ESC_DEPTH-1:0] esc_vld_reg;
    logic                  hi_hit_reg;
    logic                  esc_hit_reg;
    logic [6:0]            hi_off;

    // codes below the first high code never use the result, point them at 0
    assign hi_off  = req.code - FHC7;
    assign hi_addr = (req.code >= FHC7) ? hi_off[HAW-1:0] : '0;

    kst_ram #(
        .WIDTH (7),
        .DEPTH (HIGH_DEPTH)
    ) u_hi_ram (
        .clk   (clk),
        .we    (req.hi_we),
        .waddr (hi_addr),
        .wdata (req.wdata),
        .re    (req.rd_en),
        .raddr (hi_addr),
        .rdata (hi_rdata)
    );

    kst_ram #(
        .WIDTH (7),
        .DEPTH (kst_pkg::ESC_DEPTH)
    ) u_esc_ram (
        .clk   (clk),
        .we    (req.esc_we),
        .waddr (req.code),
        .wdata (req.wdata),
        .re    (req.rd_en),
        .raddr (req.code),
        .rdata (esc_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_vld_reg  <= '0;
            esc_vld_reg <= '0;
            hi_hit_reg  <= 1'b0;
            esc_hit_reg <= 1'b0;
        end
        else
        begin
            if (req.hi_we)
            begin
                hi_vld_reg[hi_addr] <= 1'b1;
            end
            if (req.esc_we)
            begin
                esc_vld_reg[req.code] <= 1'b1;
            end
            if (req.rd_en)
            begin
                hi_hit_reg  <= hi_vld_reg[hi_addr];
                esc_hit_reg <= esc_vld_reg[req.code];
            end
        end
    end

    assign hi_entry  = hi_hit_reg  ? hi_rdata  : kst_pkg::high_default(held_code);
    assign esc_entry = esc_hit_reg ? esc_rdata : kst_pkg::esc_default(held_code);

endmodule

[rtl/kst_xlate.sv]
// Prefix state machine and result decode for the item in the input register.
// Depends on kst_pkg.

module kst_xlate #(
    parameter int FIRST_HIGH_CODE = kst_pkg::FIRST_HIGH_CODE
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  kst_pkg::item_t item,
    input  logic [6:0]     hi_entry,
    input  logic [6:0]     esc_entry,
    output kst_pkg::res_t  result
);

    localparam logic [6:0] FHC7 = 7'(FIRST_HIGH_CODE);

    kst_pkg::prefix_t prefix_reg;
    kst_pkg::prefix_t prefix_next;
    logic [7:0]       sc;
    logic             sc_low;

    assign sc     = item.scancode;
    assign sc_low = !sc[7] && (sc[6:0] < FHC7);

    always_comb
    begin
        prefix_next = prefix_reg;
        if (item.req == kst_pkg::REQ_XLATE)
        begin
            priority if (sc == kst_pkg::SC_E0)
            begin
                prefix_next = kst_pkg::PS_E0;
            end
            else if (sc == kst_pkg::SC_E1)
            begin
                prefix_next = kst_pkg::PS_E1;
            end
            else if (prefix_reg == kst_pkg::PS_E1 && sc == kst_pkg::SC_1D)
            begin
                prefix_next = kst_pkg::PS_E1_1D;
            end
            else
            begin
                prefix_next = kst_pkg::PS_NONE;
            end
        end
    end

    always_comb
    begin
        result.status  = kst_pkg::ST_INVALID;
        result.keycode = 7'd0;
        unique case (item.req)
            kst_pkg::REQ_XLATE:
            begin
                priority if (sc == kst_pkg::SC_E0 || sc == kst_pkg::SC_E1)
                begin
                    result.status = kst_pkg::ST_CONSUMED;
                end
                else if (prefix_reg == kst_pkg::PS_E1)
                begin
                    result.status = (sc == kst_pkg::SC_1D) ? kst_pkg::ST_CONSUMED
                                                           : kst_pkg::ST_UNKNOWN;
                end
                else if (prefix_reg == kst_pkg::PS_E1_1D)
                begin
                    if (sc == kst_pkg::SC_45)
                    begin
                        result.status  = kst_pkg::ST_VALID;
                        result.keycode = kst_pkg::PAUSE_KEY;
                    end
                    else
                    begin
                        result.status = kst_pkg::ST_UNKNOWN;
                    end
                end
                else if (prefix_reg == kst_pkg::PS_E0)
                begin
                    // fake shift make codes (2A, 36) after E0 are swallowed
                    if (sc == kst_pkg::SC_LSHFT || sc == kst_pkg::SC_RSHFT)
                    begin
                        result.status = kst_pkg::ST_CONSUMED;
                    end
                    else if (!sc[7] && esc_entry != 7'd0)
                    begin
                        result.status  = kst_pkg::ST_VALID;
                        result.keycode = esc_entry;
                    end
                    else
                    begin
                        result.status = kst_pkg::ST_UNKNOWN;
                    end
                end
                else if (sc_low)
                begin
                    result.status  = kst_pkg::ST_VALID;
                    result.keycode = sc[6:0];
                end
                else if (!sc[7] && hi_entry != 7'd0)
                begin
                    result.status  = kst_pkg::ST_VALID;
                    result.keycode = hi_entry;
                end
                else
                begin
                    result.status = kst_pkg::ST_UNKNOWN;
                end
            end
            kst_pkg::REQ_WRITE:
            begin
                result.status = (sc_low || item.nk_bad) ? kst_pkg::ST_INVALID
                                                        : kst_pkg::ST_CONSUMED;
            end
            kst_pkg::REQ_READ:
            begin
                if (!sc_low)
                begin
                    result.status  = kst_pkg::ST_VALID;
                    result.keycode = sc[7] ? esc_entry : hi_entry;
                end
            end
            kst_pkg::REQ_BAD:
            begin
                result.status = kst_pkg::ST_INVALID;
            end
            default:
            begin
                result.status = kst_pkg::ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= kst_pkg::PS_NONE;
        end
        else if (advance)
        begin
            prefix_reg <= prefix_next;
        end
    end

endmodule

[rtl/kst_checker.sv]
// Port-level checks for the scancode translator, bound to the top level.
// Depends on kst_pkg and keyboard_scancode_to_keycode_core.

module kst_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_axis_tvalid) |-> $past(m_axis_tready))
        else $error("result item withdrawn before being taken");

    // keycode is only carried with a valid status
    a_kc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != 2'(kst_pkg::ST_VALID)) |->
            m_axis_tdata == 8'd0)
        else $error("nonzero keycode with non-valid status");

    // input side only stalls when both stages are full and output is blocked
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with room in the pipeline");

    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result valid straight out of reset");

endmodule

bind keyboard_scancode_to_keycode_core kst_checker u_kst_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
